FILE: hw/rtl/passive_shield_temp_correction_defines.svh
// Assertion helpers shared by the RTL. Each use names its label and the
// two sides of the implication; clk and rst_n are taken from the module.
`ifndef PASSIVE_SHIELD_TEMP_CORRECTION_DEFINES_SVH
`define PASSIVE_SHIELD_TEMP_CORRECTION_DEFINES_SVH

// Same-cycle implication.
`define PSTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pstc same-cycle check failed");

// Next-cycle implication.
`define PSTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pstc next-cycle check failed");

`endif

FILE: hw/rtl/pstc_pkg.sv
package pstc_pkg;

  // Input word, fields in channel order.
  typedef struct packed {
    logic [15:0] air_temp;
    logic        air_temp_valid;
    logic [14:0] incoming_sw;
    logic        incoming_sw_valid;
    logic [14:0] reflected_sw;
    logic        reflected_sw_valid;
    logic [13:0] wind_speed;
    logic        wind_speed_valid;
    logic [13:0] snow_height;
    logic        snow_height_valid;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [15:0] corrected_temp;
    logic        temp_out_valid;
    logic        correction_applied;
  } out_word_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SOFT_MODE = 2'd0;
  localparam logic [1:0] CFG_MODEL_SEL = 2'd1;
  localparam logic [1:0] CFG_USER_ALB  = 2'd2;

  // Divider and square-root geometry.
  localparam int ALB_NW  = 25;
  localparam int ALB_DW  = 15;
  localparam int ALB_QW  = 11;
  localparam int DIV_NW  = 54;
  localparam int DIV_DW  = 51;
  localparam int DIV_QW  = 28;
  localparam int SQ_RADW = 28;
  localparam int SIDE_W  = 8;

  // Thresholds and albedo values.
  localparam logic [14:0] FLUX_MIN       = 15'd50;
  localparam logic [13:0] SNOW_DEPTH_MIN = 14'd100;
  localparam logic [13:0] WIND_MIN       = 14'd10;
  localparam logic [10:0] SNOW_ALB       = 11'd573;
  localparam logic [10:0] SOIL_ALB       = 11'd236;
  localparam logic [10:0] ALB_MAX        = 11'd2047;
  localparam logic [10:0] USER_ALB_RST   = 11'd236;

  // Flux rebuild: r * frac / 100, the division done by a reciprocal.
  localparam logic [5:0]  SNOW_FRAC = 6'd56;
  localparam logic [5:0]  SOIL_FRAC = 6'd23;
  localparam logic [20:0] RCP100    = 21'd1342178;
  localparam int          RCP_SHIFT = 27;

  // Scale factors of the error models.
  localparam logic [13:0] K_DEN     = 14'd12048;
  localparam logic [6:0]  K_LIN_DEN = 7'd92;
  localparam logic [29:0] K_SQ_NUM  = 30'd961000000;
  localparam logic [26:0] K_CMP     = 27'd100000000;
  localparam logic [27:0] K_LIN_NUM = 28'd145859375;
  localparam logic [3:0]  K_LIN_OFS = 4'd13;

endpackage

FILE: hw/rtl/pstc_div.sv
// Pipelined restoring divider: one quotient bit per stage, with an entry
// stage that flags quotients that do not fit in QW bits.
module pstc_div #(
  parameter int NW = pstc_pkg::DIV_NW,
  parameter int DW = pstc_pkg::DIV_DW,
  parameter int QW = pstc_pkg::DIV_QW,
  parameter int SW = pstc_pkg::SIDE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic          sat,
  output logic [SW-1:0] out_side
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_r  [0:QW];
  logic [RW-1:0] rem_r  [0:QW];
  logic [DW-1:0] den_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic          sat_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];

  // Entry stage: capture operands and check for quotient overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= RW'(num);
      den_r[0]  <= den;
      q_r[0]    <= '0;
      sat_r[0]  <= RW'(num) >= (RW'(den) << QW);
      side_r[0] <= in_side;
    end
  end

  // One compare and subtract per stage, most significant bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(den_r[k-1]) << B;
    assign ge    = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? rem_r[k-1] - trial : rem_r[k-1];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= q_r[k-1] | (QW'(ge) << B);
        sat_r[k]  <= sat_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign quo      = q_r[QW];
  assign sat      = sat_r[QW];
  assign out_side = side_r[QW];

endmodule

FILE: hw/rtl/pstc_sqrt.sv
// Pipelined integer square root: one result bit per stage, two radicand
// bits brought down each time.
module pstc_sqrt #(
  parameter int RADW = pstc_pkg::SQ_RADW,
  parameter int SW   = pstc_pkg::SIDE_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [RADW-1:0]   rad,
  input  logic [SW-1:0]     in_side,
  output logic              out_vld,
  output logic [RADW/2-1:0] root,
  output logic [SW-1:0]     out_side
);

  localparam int RTW = RADW / 2;
  localparam int RMW = RTW + 2;

  logic            vld_r  [1:RTW];
  logic [RMW-1:0]  rem_r  [1:RTW];
  logic [RTW-1:0]  root_r [1:RTW];
  logic [RADW-1:0] rad_r  [1:RTW];
  logic [SW-1:0]   side_r [1:RTW];

  for (genvar k = 1; k <= RTW; k++) begin : g_step
    localparam int I = RTW - k;
    logic            p_vld;
    logic [RMW-1:0]  p_rem;
    logic [RTW-1:0]  p_root;
    logic [RADW-1:0] p_rad;
    logic [SW-1:0]   p_side;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic            ge;

    // The first stage starts from a zero remainder and root.
    if (k == 1) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = rad;
      assign p_side = in_side;
    end else begin : g_rest
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_rad  = rad_r[k-1];
      assign p_side = side_r[k-1];
    end

    assign rem_sh = {p_rem[RMW-3:0], p_rad[2*I+1 -: 2]};
    assign trial  = {p_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {p_root[RTW-2:0], ge};
        rad_r[k]  <= p_rad;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[RTW];
  assign root     = root_r[RTW];
  assign out_side = side_r[RTW];

endmodule

FILE: hw/rtl/passive_shield_temp_correction.sv
// Radiative correction of passively shielded air temperature readings.
//
// Input channel in_valid/in_stall/in_word carries one record per word;
// result channel out_valid/out_stall/out_word returns one corrected word
// per record, in order. A word moves at a clock edge where valid is high
// and stall is low. Configuration is written through cfg_we, cfg_index
// and cfg_data, one register per cycle; the user must write it only while
// no record is in flight, as the block itself does not enforce this.
//
// A word passes the albedo divider, stages B to E for rebuild and scaling
// products, the main divider, the square-root pipeline and the output
// register. One record is accepted every cycle while no result is held;
// the depth comes from the one-bit-per-stage dividers and square root.
//
// Reset clears all valid bits and loads the registers with soft mode off,
// the square-root model and a default albedo of 236/1024. When the
// receiver stalls a waiting result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is dropped or repeated.
`include "passive_shield_temp_correction_defines.svh"

module passive_shield_temp_correction (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pstc_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pstc_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data
);
  import pstc_pkg::*;

  typedef struct packed {
    logic [15:0] t;
    logic        t_ok;
    logic        use_err;
  } ms_side_t;

  typedef struct packed {
    logic [15:0]       t;
    logic              t_ok;
    logic              use_err;
    logic              sat;
    logic [DIV_QW-1:0] q;
  } sq_side_t;

  localparam int IW_W = $bits(in_word_t);
  localparam int MS_W = $bits(ms_side_t);
  localparam int SQ_W = $bits(sq_side_t);

  logic        adv;
  logic        soft_mode_r;
  logic        model_sel_r;
  logic [10:0] user_alb_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_mode_r <= 1'b0;
      model_sel_r <= 1'b0;
      user_alb_r  <= USER_ALB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOFT_MODE: soft_mode_r <= cfg_data[0];
        CFG_MODEL_SEL: model_sel_r <= cfg_data[0];
        CFG_USER_ALB:  user_alb_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a finished result is held.
  logic      out_valid_r;
  out_word_t out_word_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Measured albedo: reflected * 1024 / incoming.
  logic              al_vld;
  logic [ALB_QW-1:0] al_q;
  logic              al_sat;
  logic [IW_W-1:0]   al_side;

  pstc_div #(
    .NW(ALB_NW),
    .DW(ALB_DW),
    .QW(ALB_QW),
    .SW(IW_W)
  ) u_alb_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .num     ({in_word.reflected_sw, 10'd0}),
    .den     (in_word.incoming_sw),
    .in_side (in_word),
    .out_vld (al_vld),
    .quo     (al_q),
    .sat     (al_sat),
    .out_side(al_side)
  );

  // Stage B: pick the albedo, decide on a flux rebuild, clamp wind.
  in_word_t    fa;
  logic        meas;
  logic        hs_ok;
  logic        snow;
  logic        rebuild_nxt;
  logic [10:0] alb_nxt;
  logic [13:0] wind_cl;

  assign fa          = al_side;
  assign meas        = soft_mode_r && fa.incoming_sw_valid && fa.reflected_sw_valid &&
                       (fa.reflected_sw > FLUX_MIN) && (fa.incoming_sw > FLUX_MIN);
  assign hs_ok       = fa.snow_height_valid && !meas;
  assign snow        = fa.snow_height > SNOW_DEPTH_MIN;
  assign rebuild_nxt = soft_mode_r && hs_ok && !fa.incoming_sw_valid && fa.reflected_sw_valid;
  assign wind_cl     = (fa.wind_speed < WIND_MIN) ? WIND_MIN : fa.wind_speed;

  always_comb begin
    priority if (soft_mode_r && hs_ok) begin
      alb_nxt = snow ? SNOW_ALB : SOIL_ALB;
    end else if (meas) begin
      alb_nxt = al_sat ? ALB_MAX : al_q;
    end else begin
      alb_nxt = user_alb_r;
    end
  end

  logic        b_vld_r;
  logic [15:0] b_t_r;
  logic        b_t_ok_r;
  logic        b_sv_ok_r;
  logic        b_rebuild_r;
  logic [14:0] b_s_r;
  logic [10:0] b_alb_r;
  logic [20:0] b_prod_r;
  logic [29:0] b_tv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= al_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_t_r       <= fa.air_temp;
      b_t_ok_r    <= fa.air_temp_valid;
      b_sv_ok_r   <= (fa.incoming_sw_valid || rebuild_nxt) && fa.wind_speed_valid;
      b_rebuild_r <= rebuild_nxt;
      b_s_r       <= fa.incoming_sw;
      b_alb_r     <= alb_nxt;
      b_prod_r    <= 21'(fa.reflected_sw) * 21'(snow ? SNOW_FRAC : SOIL_FRAC);
      b_tv_r      <= 30'(fa.air_temp) * 30'(wind_cl);
    end
  end

  // Stage C: finish the rebuilt flux and scale the denominator.
  logic [41:0] rcp_prod;
  logic        c_vld_r;
  logic [15:0] c_t_r;
  logic        c_t_ok_r;
  logic        c_sv_ok_r;
  logic [14:0] c_s_r;
  logic [10:0] c_alb_r;
  logic [43:0] c_tv12_r;

  assign rcp_prod = 42'(b_prod_r) * 42'(RCP100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_t_r     <= b_t_r;
      c_t_ok_r  <= b_t_ok_r;
      c_sv_ok_r <= b_sv_ok_r;
      c_s_r     <= b_rebuild_r ? rcp_prod[RCP_SHIFT +: 15] : b_s_r;
      c_alb_r   <= b_alb_r;
      c_tv12_r  <= 44'(b_tv_r) * 44'(K_DEN);
    end
  end

  // Stage D: first products of both numerators and the threshold.
  logic        d_vld_r;
  logic [15:0] d_t_r;
  logic        d_t_ok_r;
  logic        d_sv_ok_r;
  logic [25:0] d_as_r;
  logic [44:0] d_ns_r;
  logic [41:0] d_s8_r;
  logic [50:0] d_dl_r;
  logic [43:0] d_tv12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_t_r     <= c_t_r;
      d_t_ok_r  <= c_t_ok_r;
      d_sv_ok_r <= c_sv_ok_r;
      d_as_r    <= 26'(c_alb_r) * 26'(c_s_r);
      d_ns_r    <= 45'(c_s_r) * 45'(K_SQ_NUM);
      d_s8_r    <= 42'(c_s_r) * 42'(K_CMP);
      d_dl_r    <= 51'(c_tv12_r) * 51'(K_LIN_DEN);
      d_tv12_r  <= c_tv12_r;
    end
  end

  // Stage E: choose the model's operands and test the threshold.
  logic              e_vld_r;
  logic [DIV_NW-1:0] e_num_r;
  logic [DIV_DW-1:0] e_den_r;
  ms_side_t          e_side_r;
  logic              apply;

  assign apply = {2'b00, d_s8_r} >= d_tv12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_num_r          <= model_sel_r ? 54'(d_as_r) * 54'(K_LIN_NUM) : 54'(d_ns_r);
      e_den_r          <= model_sel_r ? d_dl_r : 51'(d_tv12_r);
      e_side_r.t       <= d_t_r;
      e_side_r.t_ok    <= d_t_ok_r;
      e_side_r.use_err <= d_t_ok_r && d_sv_ok_r && apply;
    end
  end

  // Main quotient of both error models.
  logic              dv_vld;
  logic [DIV_QW-1:0] dv_q;
  logic              dv_sat;
  logic [MS_W-1:0]   dv_side;
  ms_side_t          ms;
  sq_side_t          sq_in;

  pstc_div #(
    .NW(DIV_NW),
    .DW(DIV_DW),
    .QW(DIV_QW),
    .SW(MS_W)
  ) u_main_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (e_vld_r),
    .num     (e_num_r),
    .den     (e_den_r),
    .in_side (e_side_r),
    .out_vld (dv_vld),
    .quo     (dv_q),
    .sat     (dv_sat),
    .out_side(dv_side)
  );

  assign ms            = dv_side;
  assign sq_in.t       = ms.t;
  assign sq_in.t_ok    = ms.t_ok;
  assign sq_in.use_err = ms.use_err;
  assign sq_in.sat     = dv_sat;
  assign sq_in.q       = dv_q;

  // Square root of the quotient; the linear model rides along unused.
  logic                 sq_vld;
  logic [SQ_RADW/2-1:0] sq_root;
  logic [SQ_W-1:0]      sq_side;
  sq_side_t             fs;

  pstc_sqrt #(
    .RADW(SQ_RADW),
    .SW  (SQ_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (dv_vld),
    .rad     (dv_q),
    .in_side (sq_in),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_side(sq_side)
  );

  assign fs = sq_side;

  // Output stage: subtract the error, saturating at zero.
  logic [DIV_QW:0] lin_err;
  logic            err_ge;
  logic [15:0]     err_lo;
  out_word_t       out_nxt;

  assign lin_err = (DIV_QW + 1)'(fs.q) + (DIV_QW + 1)'(K_LIN_OFS);
  assign err_ge  = model_sel_r ?
                   (fs.sat || (lin_err >= (DIV_QW + 1)'(fs.t))) :
                   (fs.sat || (16'(sq_root) >= fs.t));
  assign err_lo  = model_sel_r ? lin_err[15:0] : 16'(sq_root);

  always_comb begin
    priority if (!fs.t_ok) begin
      out_nxt.corrected_temp     = '0;
      out_nxt.temp_out_valid     = 1'b0;
      out_nxt.correction_applied = 1'b0;
    end else if (!fs.use_err) begin
      out_nxt.corrected_temp     = fs.t;
      out_nxt.temp_out_valid     = 1'b1;
      out_nxt.correction_applied = 1'b0;
    end else begin
      out_nxt.corrected_temp     = err_ge ? 16'd0 : fs.t - err_lo;
      out_nxt.temp_out_valid     = 1'b1;
      out_nxt.correction_applied = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= out_nxt;
    end
  end

  // Checks on the pipeline control and the result flags.
  `PSTC_ASSERT_IMP(a_hold_stalls_in, out_valid_r && out_stall, in_stall)
  `PSTC_ASSERT_IMP(a_applied_has_temp, out_valid_r && out_word_r.correction_applied, out_word_r.temp_out_valid)
  `PSTC_ASSERT_IMP(a_nodata_is_zero, out_valid_r && !out_word_r.temp_out_valid, out_word_r.corrected_temp == 16'd0 && !out_word_r.correction_applied)
  `PSTC_ASSERT_NXT(a_stage_b_frozen, !adv && b_vld_r, b_vld_r)

endmodule
